/* rtl/prime_sieve_table_defines.svh */
// ----------------------------------------------------------------------------
// prime_sieve_table_defines
// Assertion macros shared by the prime sieve table RTL.
// ----------------------------------------------------------------------------
`ifndef PRIME_SIEVE_TABLE_DEFINES_SVH
`define PRIME_SIEVE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pst_pkg.sv */
// ----------------------------------------------------------------------------
// pst_pkg
// Shared constants, codes and types of the prime sieve table.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

   // Default size of the composite map, in entries.
   localparam int unsigned MAX_NUMBERS_DEF = 65536;

   // Width of the limit register and of a queried number.
   localparam int unsigned NUM_W = 16;

   // Candidate factor and its square; a 16-bit limit needs factors up to 256.
   localparam int unsigned IW   = 9;
   localparam int unsigned SQ_W = 18;

   // Input action codes.
   localparam logic ACT_RUN   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Result handed from the sieve core to the output register.
   typedef struct packed {
      logic load;
      logic is_prime;
      logic answer_valid;
      logic run_complete;
   } pst_result_type;

endpackage

`default_nettype wire

/* rtl/pst_core.sv */
// ----------------------------------------------------------------------------
// pst_core
// Composite map memory and the sequencer that sweeps, sieves and answers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "prime_sieve_table_defines.svh"

module pst_core #(
   parameter int unsigned MAX_NUMBERS = pst_pkg::MAX_NUMBERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start_valid,
   output logic                        start_ready,
   input  logic                        start_action,
   input  logic [pst_pkg::NUM_W-1:0]   start_number,
   input  logic [pst_pkg::NUM_W-1:0]   limit,
   input  logic                        slot_free,
   output pst_pkg::pst_result_type     result
);
   import pst_pkg::*;

   localparam int unsigned AW = $clog2(MAX_NUMBERS);
   localparam int unsigned CW = ((AW > SQ_W) ? AW : SQ_W) + 1;
   localparam logic [CW-1:0] TOP_C = CW'(MAX_NUMBERS - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_QWAIT, ST_INIT, ST_TEST, ST_CHECK, ST_MARK, ST_DONE
   } state_type;

   state_type          state_ff;
   logic               sieved_ff;
   logic               q_hit_ff;
   logic [AW-1:0]      run_limit_ff;
   logic [CW-1:0]      cnt_ff;
   logic [IW-1:0]      i_ff;
   logic [SQ_W-1:0]    i_sq_ff;
   logic               map_ff [MAX_NUMBERS];
   logic               rd_data_ff;

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               wr_data;
   logic [CW-1:0]      limit_c;
   logic [CW-1:0]      sat_c;
   logic [CW-1:0]      lim_c;
   logic [CW-1:0]      num_c;
   logic [CW-1:0]      i_c;
   logic [CW-1:0]      i_sq_c;
   logic [CW-1:0]      sweep_end;
   logic [SQ_W-1:0]    i_sq_in;

   assign limit_c   = CW'(limit);
   assign sat_c     = (limit_c > TOP_C) ? TOP_C : limit_c;
   assign lim_c     = CW'(run_limit_ff);
   assign num_c     = CW'(start_number);
   assign i_c       = CW'(i_ff);
   assign i_sq_c    = CW'(i_sq_ff);
   // Entries 0 and 1 are always marked, even for a limit below 2.
   assign sweep_end = (lim_c < CW'(1)) ? CW'(1) : lim_c;
   // (i+1)^2 = i^2 + 2i + 1
   assign i_sq_in   = SQ_W'(i_sq_ff + (SQ_W'(i_ff) << 1) + SQ_W'(1));

   assign start_ready = (state_ff == ST_IDLE);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = num_c[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      wr_data = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (start_valid && (start_action == ACT_QUERY)) rd_en = 1'b1;
         end
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = (cnt_ff < CW'(2));
         end
         ST_TEST: begin
            if (i_sq_c <= lim_c) begin
               rd_en   = 1'b1;
               rd_addr = i_c[AW-1:0];
            end
         end
         ST_MARK: begin
            if (cnt_ff <= lim_c) wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.load         = slot_free && ((state_ff == ST_QWAIT) || (state_ff == ST_DONE));
      result.is_prime     = (state_ff == ST_QWAIT) && q_hit_ff && !rd_data_ff;
      result.answer_valid = (state_ff == ST_QWAIT) && q_hit_ff;
      result.run_complete = (state_ff == ST_DONE);
   end

   // Single-port-write, single-port-read map; read data is held when not read.
   always_ff @(posedge clock) begin
      if (wr_en) map_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= map_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sieved_ff    <= 1'b0;
         run_limit_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start_valid) begin
                  if (start_action == ACT_QUERY) begin
                     q_hit_ff <= sieved_ff && (num_c <= lim_c);
                     state_ff <= ST_QWAIT;
                  end else begin
                     run_limit_ff <= sat_c[AW-1:0];
                     cnt_ff       <= '0;
                     state_ff     <= ST_INIT;
                  end
               end
            end
            ST_QWAIT: begin
               if (slot_free) state_ff <= ST_IDLE;
            end
            ST_INIT: begin
               if (cnt_ff >= sweep_end) begin
                  i_ff     <= IW'(2);
                  i_sq_ff  <= SQ_W'(4);
                  state_ff <= ST_TEST;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_TEST: begin
               if (i_sq_c > lim_c) state_ff <= ST_DONE;
               else state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (rd_data_ff) begin
                  i_ff     <= i_ff + IW'(1);
                  i_sq_ff  <= i_sq_in;
                  state_ff <= ST_TEST;
               end else begin
                  cnt_ff   <= CW'({i_ff, 1'b0});
                  state_ff <= ST_MARK;
               end
            end
            ST_MARK: begin
               if (cnt_ff > lim_c) begin
                  i_ff     <= i_ff + IW'(1);
                  i_sq_ff  <= i_sq_in;
                  state_ff <= ST_TEST;
               end else begin
                  cnt_ff <= cnt_ff + i_c;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  sieved_ff <= 1'b1;
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `PST_ASSERT_IMP(a_write_in_run, clock, reset, wr_en, (state_ff == ST_INIT) || (state_ff == ST_MARK), "map written outside a run")
   `PST_ASSERT_IMP(a_mark_in_range, clock, reset, wr_en && (state_ff == ST_MARK), CW'(wr_addr) <= lim_c, "mark beyond the run limit")
   `PST_ASSERT_IMP(a_square_track, clock, reset, state_ff == ST_TEST, i_sq_ff == SQ_W'(SQ_W'(i_ff) * SQ_W'(i_ff)), "factor square out of step")
   `PST_ASSERT_NEXT(a_query_reads, clock, reset, (state_ff == ST_IDLE) && start_valid && (start_action == ACT_QUERY), state_ff == ST_QWAIT, "query did not wait for map data")
   `PST_ASSERT_IMP(a_hit_after_run, clock, reset, (state_ff == ST_QWAIT) && q_hit_ff, sieved_ff, "valid answer before any run")

endmodule

`default_nettype wire

/* rtl/prime_sieve_table.sv */
// ----------------------------------------------------------------------------
// prime_sieve_table
// Sieve of Eratosthenes over a one-bit composite map, with prime queries.
// Query: one transfer in; the map bit is read on acceptance, and from the QWAIT state
// the result is loaded into the output register once free; only then is a new item taken.
// Run: a sweep marks entries 0 and 1 and clears the rest up to max(limit,1); then each
// factor p with p*p <= limit is tested, and each prime p marks its multiples from 2p.
// Reset is synchronous and active high; the map is not cleared, so queries before
// the first run answer with answer_valid low.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sieve_table #(
   parameter int unsigned MAX_NUMBERS = pst_pkg::MAX_NUMBERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [pst_pkg::NUM_W-1:0]   req_tdata,   // [15:0] number
   input  logic                        req_tuser,   // [0] action: 0 run, 1 query
   // Result channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [0] is_prime, [1] answer_valid
   output logic                        rsp_tuser,   // [0] run_complete
   // Limit register write port.
   input  logic                        csr_we,
   input  logic [pst_pkg::NUM_W-1:0]   csr_wdata
);
   import pst_pkg::*;

   // The sieve limit. A run latches it, saturated to the map size, so that a
   // later write does not disturb the answers to queries until the next run.
   logic [NUM_W-1:0]   csr_limit_ff;

   // Output register. It parts the core from the result channel, so the core
   // can take the next item while a finished result still waits for its transfer.
   logic               rsp_valid_ff;
   logic               is_prime_ff;
   logic               answer_valid_ff;
   logic               run_complete_ff;

   logic               slot_free;
   pst_result_type     result;

   // The register is free when it is empty or its content leaves on this edge.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_limit_ff <= '0;
      end else if (csr_we) begin
         csr_limit_ff <= csr_wdata;
      end
   end

   // The core holds the composite map and runs both the sieve and the queries.
   pst_core #(
      .MAX_NUMBERS (MAX_NUMBERS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .start_valid  (req_tvalid),
      .start_ready  (req_tready),
      .start_action (req_tuser),
      .start_number (req_tdata),
      .limit        (csr_limit_ff),
      .slot_free    (slot_free),
      .result       (result)
   );

   // Valid is control state and is reset; the result fields are payload only.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         is_prime_ff     <= result.is_prime;
         answer_valid_ff <= result.answer_valid;
         run_complete_ff <= result.run_complete;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, answer_valid_ff, is_prime_ff};
   assign rsp_tuser  = run_complete_ff;

endmodule

`default_nettype wire
